>>> hdl/lpfd_pkg.sv
package lpfd_pkg;

   localparam int BYTE_W   = 8;
   localparam int LENGTH_W = 16;
   localparam int STATUS_W = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [STATUS_W-1:0] STATUS_FORWARD   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_START = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_TYPE       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_BODY_LENGTH = 2'd2;

   localparam logic [BYTE_W-1:0]   START_BYTE_RESET      = 8'h54;
   localparam logic [BYTE_W-1:0]   DATA_TYPE_RESET       = 8'h55;
   localparam logic [LENGTH_W-1:0] MAX_BODY_LENGTH_RESET = 16'd10240;

   typedef struct packed {
      logic [BYTE_W-1:0]   start_byte;
      logic [BYTE_W-1:0]   data_type;
      logic [LENGTH_W-1:0] max_body_length;
   } cfg_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   out_byte;
      logic                last_of_frame;
   } result_type;

endpackage

>>> hdl/lpfd_req_if.sv
interface lpfd_req_if;

   logic                      valid;
   logic                      ready;
   logic [lpfd_pkg::BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);

endinterface

>>> hdl/lpfd_rsp_if.sv
interface lpfd_rsp_if;

   logic                          valid;
   logic                          ready;
   logic [lpfd_pkg::STATUS_W-1:0] status;
   logic [lpfd_pkg::BYTE_W-1:0]   out_byte;
   logic                          last_of_frame;

   modport source (output valid, output status, output out_byte, output last_of_frame,
                   input ready);
   modport sink   (input valid, input status, input out_byte, input last_of_frame,
                   output ready);

endinterface

>>> hdl/length_prefixed_frame_deframer.sv
// Channel   Direction  Handshake     Payload
// req_if    in         valid/ready   in_byte[7:0]
// rsp_if    out        valid/ready   status[1:0], out_byte[7:0], last_of_frame
// csr_*     in         write enable  csr_index[1:0], csr_write_data[15:0]
//
// One byte per cycle unless rsp_if stalls; a byte's result, if any, is registered for rsp_if.
// Rate is set by the single parse step between the input register and the result register.
// Reset is synchronous and returns the parser to hunting for a start byte.
// A stalled result holds the input register; the input still takes a byte in the cycle
// the result is taken.
module length_prefixed_frame_deframer (
   input  logic                              clock,
   input  logic                              reset,
   lpfd_req_if.sink                          req_if,
   lpfd_rsp_if.source                        rsp_if,
   input  logic                              csr_write_enable,
   input  logic [lpfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lpfd_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   lpfd_pkg::cfg_type             cfg;
   logic                          in_valid_ff;
   logic [lpfd_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                          out_valid_ff, out_valid_in;
   lpfd_pkg::result_type          out_ff;
   logic                          out_free;
   logic                          advance;
   logic                          result_valid;
   lpfd_pkg::result_type          result;

   lpfd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   lpfd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .advance      (advance),
      .in_byte      (in_byte_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_if.ready = !in_valid_ff || advance;
   assign out_valid_in = advance && result_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_byte_ff <= req_if.in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && out_valid_in) begin
         out_ff <= result;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.status        = out_ff.status;
   assign rsp_if.out_byte      = out_ff.out_byte;
   assign rsp_if.last_of_frame = out_ff.last_of_frame;

endmodule

>>> hdl/lpfd_csr.sv
module lpfd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [lpfd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lpfd_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output lpfd_pkg::cfg_type                   cfg
);

   lpfd_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte      <= lpfd_pkg::START_BYTE_RESET;
         cfg_ff.data_type       <= lpfd_pkg::DATA_TYPE_RESET;
         cfg_ff.max_body_length <= lpfd_pkg::MAX_BODY_LENGTH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lpfd_pkg::CSR_START_BYTE: begin
               cfg_ff.start_byte <= csr_write_data[lpfd_pkg::BYTE_W-1:0];
            end
            lpfd_pkg::CSR_DATA_TYPE: begin
               cfg_ff.data_type <= csr_write_data[lpfd_pkg::BYTE_W-1:0];
            end
            lpfd_pkg::CSR_MAX_BODY_LENGTH: begin
               cfg_ff.max_body_length <= csr_write_data[lpfd_pkg::LENGTH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/lpfd_parser.sv
module lpfd_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  lpfd_pkg::cfg_type             cfg,
   input  logic                          advance,
   input  logic [lpfd_pkg::BYTE_W-1:0]   in_byte,
   output logic                          result_valid,
   output lpfd_pkg::result_type          result
);

   typedef enum logic [2:0] {
      POS_START  = 3'd0,
      POS_TYPE   = 3'd1,
      POS_LEN_LO = 3'd2,
      POS_LEN_HI = 3'd3,
      POS_BODY   = 3'd4
   } pos_type;

   pos_type                         pos_ff, pos_in;
   logic                            start_matched_ff, start_matched_in;
   logic [lpfd_pkg::BYTE_W-1:0]     frame_type_ff, frame_type_in;
   logic [lpfd_pkg::BYTE_W-1:0]     length_low_ff, length_low_in;
   logic [lpfd_pkg::LENGTH_W-1:0]   remaining_ff, remaining_in;
   logic [lpfd_pkg::LENGTH_W-1:0]   length;

   assign length = {in_byte, length_low_ff};

   always_comb begin
      pos_in           = pos_ff;
      start_matched_in = start_matched_ff;
      frame_type_in    = frame_type_ff;
      length_low_in    = length_low_ff;
      remaining_in     = remaining_ff;
      result_valid     = 1'b0;
      result           = '0;
      unique case (pos_ff)
         POS_START: begin
            start_matched_in = (in_byte == cfg.start_byte);
            pos_in           = POS_TYPE;
         end
         POS_TYPE: begin
            frame_type_in = in_byte;
            pos_in        = POS_LEN_LO;
         end
         POS_LEN_LO: begin
            length_low_in = in_byte;
            pos_in        = POS_LEN_HI;
         end
         POS_LEN_HI: begin
            pos_in = POS_START;
            if (!start_matched_ff) begin
               result_valid  = 1'b1;
               result.status = lpfd_pkg::STATUS_BAD_START;
            end else if (length > cfg.max_body_length) begin
               result_valid  = 1'b1;
               result.status = lpfd_pkg::STATUS_TOO_LONG;
            end else if (length != '0) begin
               remaining_in = length;
               pos_in       = POS_BODY;
            end
         end
         default: begin
            if (remaining_ff == '0) begin
               pos_in = POS_START;
            end else begin
               remaining_in = remaining_ff - lpfd_pkg::LENGTH_W'(1);
               if (remaining_ff == lpfd_pkg::LENGTH_W'(1)) begin
                  pos_in = POS_START;
               end
               if (frame_type_ff == cfg.data_type) begin
                  result_valid         = 1'b1;
                  result.status        = lpfd_pkg::STATUS_FORWARD;
                  result.out_byte      = in_byte;
                  result.last_of_frame = (remaining_ff == lpfd_pkg::LENGTH_W'(1));
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff           <= POS_START;
         start_matched_ff <= 1'b0;
         frame_type_ff    <= '0;
         length_low_ff    <= '0;
         remaining_ff     <= '0;
      end else if (advance) begin
         pos_ff           <= pos_in;
         start_matched_ff <= start_matched_in;
         frame_type_ff    <= frame_type_in;
         length_low_ff    <= length_low_in;
         remaining_ff     <= remaining_in;
      end
   end

endmodule
